// File: rtl/core/lxc_pkg.sv
// ----------------------------------------------------------------------------
// lxc_pkg
// Types and constants shared by the cipher core, its channels and its checker.
// ----------------------------------------------------------------------------
package lxc_pkg;

	localparam logic [31:0] LCG_MUL = 32'h41C6_4E6D;
	localparam logic [31:0] LCG_ADD = 32'h0000_6073;

	localparam logic [1:0] FUNC_DECRYPT  = 2'd0;
	localparam logic [1:0] FUNC_ENCRYPT  = 2'd1;
	localparam logic [1:0] FUNC_CHECKSUM = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] data_word;
		logic        first_word;
		logic [31:0] seed_value;
		logic        last_word;
	} in_item_t;

	typedef struct packed {
		logic [15:0] out_word;
		logic [15:0] running_sum;
		logic        last_out;
		logic        sum_matches;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] data_word;
		logic [15:0] key;
		logic [15:0] expected;
		logic        first_word;
		logic        last_word;
	} key_item_t;

endpackage

// File: rtl/core/lxc_in_if.sv
// ----------------------------------------------------------------------------
// lxc_in_if
// Request channel carrying one record word with its control bits.
// ----------------------------------------------------------------------------
interface lxc_in_if;
	logic              valid;
	logic              ready;
	lxc_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/lxc_out_if.sv
// ----------------------------------------------------------------------------
// lxc_out_if
// Result channel carrying one transformed word with its checksum status.
// ----------------------------------------------------------------------------
interface lxc_out_if;
	logic               valid;
	logic               ready;
	lxc_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/lcg_xor_cipher_with_checksum_core.sv
// ----------------------------------------------------------------------------
// lcg_xor_cipher_with_checksum_core
// Stream cipher over 16-bit record words with an additive plaintext checksum.
// ----------------------------------------------------------------------------
// Each accepted request is registered in item_s1, key_s2 and out_s3 in turn.
// Throughput: one word per cycle while dout is not stalled.
// Stalls on dout back up stage by stage, and empty stages keep taking words.
// Reset clears the generator state, checksum, expected sum and all valid bits.
module lcg_xor_cipher_with_checksum_core (
	input logic         clk,
	input logic         arst_n,
	lxc_in_if.sink      din,
	lxc_out_if.source   dout
);

	logic               v_s1;
	logic               v_s2;
	logic               v_s3;
	logic               rdy1;
	logic               rdy2;
	logic               rdy3;
	logic               adv2;
	logic               adv3;
	lxc_pkg::in_item_t  item_s1;
	lxc_pkg::key_item_t key_s2;
	lxc_pkg::out_item_t out_s3;

	assign rdy3 = !v_s3 || dout.ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign adv2 = v_s1 && rdy2;
	assign adv3 = v_s2 && rdy3;

	assign din.ready  = rdy1;
	assign dout.valid = v_s3;
	assign dout.data  = out_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= din.valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && rdy1) begin
			item_s1 <= din.data;
		end
	end

	lxc_lcg u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv2),
		.item   (item_s1),
		.key_s2 (key_s2)
	);

	lxc_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv3),
		.key_s2 (key_s2),
		.out_s3 (out_s3)
	);

endmodule

// File: rtl/core/lxc_lcg.sv
// ----------------------------------------------------------------------------
// lxc_lcg
// Generator stage: reseeds on the first word, advances the state and
// registers the keystream word together with the request.
// ----------------------------------------------------------------------------
module lxc_lcg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  lxc_pkg::in_item_t  item,
	output lxc_pkg::key_item_t key_s2
);

	logic [31:0] state_q;
	logic [15:0] expected_q;
	logic [31:0] base;
	logic [31:0] state_nxt;
	logic [15:0] expected_nxt;

	always_comb begin
		base         = item.first_word ? item.seed_value : state_q;
		expected_nxt = item.first_word ? item.seed_value[15:0] : expected_q;
		state_nxt    = base * lxc_pkg::LCG_MUL + lxc_pkg::LCG_ADD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= '0;
			expected_q <= '0;
		end else if (adv) begin
			state_q    <= state_nxt;
			expected_q <= expected_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_s2.func       <= item.func;
			key_s2.data_word  <= item.data_word;
			key_s2.key        <= state_nxt[31:16];
			key_s2.expected   <= expected_nxt;
			key_s2.first_word <= item.first_word;
			key_s2.last_word  <= item.last_word;
		end
	end

endmodule

// File: rtl/core/lxc_mix.sv
// ----------------------------------------------------------------------------
// lxc_mix
// Result stage: applies the keystream on decrypt and encrypt, accumulates the
// plaintext checksum and registers the result word.
// ----------------------------------------------------------------------------
module lxc_mix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  lxc_pkg::key_item_t key_s2,
	output lxc_pkg::out_item_t out_s3
);

	logic [15:0] sum_q;
	logic [15:0] result;
	logic [15:0] plain;
	logic [15:0] sum_nxt;

	always_comb begin
		case (key_s2.func)
			lxc_pkg::FUNC_DECRYPT: begin
				result = key_s2.data_word ^ key_s2.key;
				plain  = result;
			end
			lxc_pkg::FUNC_ENCRYPT: begin
				result = key_s2.data_word ^ key_s2.key;
				plain  = key_s2.data_word;
			end
			default: begin
				result = key_s2.data_word;
				plain  = key_s2.data_word;
			end
		endcase
		sum_nxt = (key_s2.first_word ? 16'd0 : sum_q) + plain;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (adv) begin
			sum_q <= sum_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s3.out_word    <= result;
			out_s3.running_sum <= sum_nxt;
			out_s3.last_out    <= key_s2.last_word;
			out_s3.sum_matches <= key_s2.last_word && (sum_nxt == key_s2.expected);
		end
	end

endmodule

// File: rtl/core/lxc_checker.sv
// ----------------------------------------------------------------------------
// lxc_checker
// Port-level checks on the cipher core, attached by bind.
// ----------------------------------------------------------------------------
module lxc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input lxc_pkg::out_item_t out_data
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	a_match_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.sum_matches || out_data.last_out))
		else $error("sum match flagged on a word that is not last");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while the result register is empty");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed or dropped");

endmodule

bind lcg_xor_cipher_with_checksum_core lxc_checker u_lxc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_data  (dout.data)
);

// File: verif/lcg_xor_cipher_with_checksum_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_xor_cipher_with_checksum_core_test
// Self-checking bench for the record cipher core. A short table of directed
// words opens the run. Random records follow: mostly well-formed, some built
// so that the checksum matches, with stray words mixed in. Both channels idle
// and stall at random. Results are checked against a local predictor or a pinned value.
// ----------------------------------------------------------------------------
module lcg_xor_cipher_with_checksum_core_test;

	localparam int RANDOM_WORDS = 950;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int TABLE_ROWS   = 20;
	localparam int PAUSE_RECORD = 30;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct {
		bit                 pinned;
		lxc_pkg::out_item_t result;
	} pinned_result_t;

	typedef struct {
		lxc_pkg::in_item_t  req;
		bit                 pinned;
		lxc_pkg::out_item_t result;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n;

	lxc_in_if  din_ch ();
	lxc_out_if dout_ch ();

	lcg_xor_cipher_with_checksum_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	logic [31:0]        lcg_state  = '0;
	logic [15:0]        plain_sum  = '0;
	logic [15:0]        target_sum = '0;
	lxc_pkg::out_item_t expected_words[$];
	pinned_result_t     pins[$];
	logic [1:0]         func_codes[4] = '{lxc_pkg::FUNC_DECRYPT, lxc_pkg::FUNC_ENCRYPT,
		lxc_pkg::FUNC_CHECKSUM, FUNC_UNUSED};
	int                 error_count   = 0;
	int                 words_issued  = 0;
	int                 words_checked = 0;
	int                 record_count  = 0;
	int                 match_count   = 0;
	int                 cycle_count   = 0;
	int                 sink_stall    = 0;
	bit                 smooth        = 1'b0;

	// Rows with a result typed in are checked against that value.
	table_row_t stim_table[TABLE_ROWS] = '{
		'{'{lxc_pkg::FUNC_CHECKSUM, 16'h0000, 1'b0, 32'h0000_0000, 1'b1}, 1'b1,
			'{16'h0000, 16'h0000, 1'b1, 1'b1}},
		'{'{lxc_pkg::FUNC_DECRYPT, 16'hFFFF, 1'b0, 32'hFFFF_FFFF, 1'b0}, 1'b0, '0},
		'{'{lxc_pkg::FUNC_CHECKSUM, 16'hFFFF, 1'b1, 32'h0000_FFFF, 1'b1}, 1'b1,
			'{16'hFFFF, 16'hFFFF, 1'b1, 1'b1}},
		'{'{lxc_pkg::FUNC_CHECKSUM, 16'hFFFF, 1'b1, 32'hFFFF_0000, 1'b1}, 1'b1,
			'{16'hFFFF, 16'hFFFF, 1'b1, 1'b0}},
		'{'{FUNC_UNUSED, 16'h8001, 1'b1, 32'h7FFE_8001, 1'b1}, 1'b1,
			'{16'h8001, 16'h8001, 1'b1, 1'b1}},
		'{'{lxc_pkg::FUNC_CHECKSUM, 16'hFFFF, 1'b1, 32'h1234_FFFE, 1'b0}, 1'b1,
			'{16'hFFFF, 16'hFFFF, 1'b0, 1'b0}},
		'{'{lxc_pkg::FUNC_CHECKSUM, 16'hFFFF, 1'b0, 32'h0000_0000, 1'b1}, 1'b1,
			'{16'hFFFF, 16'hFFFE, 1'b1, 1'b1}},
		'{'{lxc_pkg::FUNC_ENCRYPT, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b0}, 1'b0, '0},
		'{'{lxc_pkg::FUNC_ENCRYPT, 16'h0000, 1'b0, 32'h0000_0000, 1'b0}, 1'b0, '0},
		'{'{lxc_pkg::FUNC_CHECKSUM, 16'hAAAA, 1'b0, 32'h0000_0000, 1'b0}, 1'b0, '0},
		'{'{lxc_pkg::FUNC_ENCRYPT, 16'h5555, 1'b0, 32'h0000_0000, 1'b1}, 1'b0, '0},
		'{'{lxc_pkg::FUNC_DECRYPT, 16'h0000, 1'b1, 32'h0000_0000, 1'b0}, 1'b0, '0},
		'{'{lxc_pkg::FUNC_DECRYPT, 16'hFFFF, 1'b0, 32'hA5A5_5A5A, 1'b0}, 1'b0, '0},
		'{'{lxc_pkg::FUNC_DECRYPT, 16'h1234, 1'b0, 32'h0000_0000, 1'b1}, 1'b0, '0},
		'{'{lxc_pkg::FUNC_ENCRYPT, 16'h8000, 1'b0, 32'h0000_0000, 1'b0}, 1'b0, '0},
		'{'{FUNC_UNUSED, 16'h0001, 1'b0, 32'h0000_0000, 1'b1}, 1'b0, '0},
		'{'{lxc_pkg::FUNC_ENCRYPT, 16'h7FFE, 1'b1, 32'h8000_0001, 1'b1}, 1'b0, '0},
		'{'{lxc_pkg::FUNC_DECRYPT, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b1}, 1'b0, '0},
		'{'{lxc_pkg::FUNC_ENCRYPT, 16'h0F0F, 1'b1, 32'h0000_1111, 1'b0}, 1'b0, '0},
		'{'{lxc_pkg::FUNC_DECRYPT, 16'hF0F0, 1'b1, 32'h5555_AAAA, 1'b1}, 1'b0, '0}
	};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [31:0] lcg_advance(logic [31:0] s);
		return s * lxc_pkg::LCG_MUL + lxc_pkg::LCG_ADD;
	endfunction

	function automatic lxc_pkg::out_item_t cipher_predict(lxc_pkg::in_item_t req);
		lxc_pkg::out_item_t res;
		logic [15:0]        key;
		logic [15:0]        plain;
		if (req.first_word) begin
			lcg_state  = req.seed_value;
			target_sum = req.seed_value[15:0];
			plain_sum  = '0;
		end
		lcg_state = lcg_advance(lcg_state);
		key = lcg_state[31:16];
		case (req.func)
			lxc_pkg::FUNC_DECRYPT: begin
				res.out_word = req.data_word ^ key;
				plain = res.out_word;
			end
			lxc_pkg::FUNC_ENCRYPT: begin
				res.out_word = req.data_word ^ key;
				plain = req.data_word;
			end
			default: begin
				res.out_word = req.data_word;
				plain = req.data_word;
			end
		endcase
		plain_sum = plain_sum + plain;
		res.running_sum = plain_sum;
		res.last_out = req.last_word;
		res.sum_matches = req.last_word && (plain_sum == target_sum);
		return res;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (smooth)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(12, 40);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		error_count++;
		$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	task automatic send_word(lxc_pkg::in_item_t req, bit pinned = 1'b0,
		lxc_pkg::out_item_t result = '0);
		int gap;
		gap = pick_gap();
		pins.push_back('{pinned, result});
		words_issued++;
		if (gap > 0) begin
			din_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_ch.valid <= 1'b1;
		din_ch.data  <= req;
		@(posedge clk);
		while (din_ch.ready !== 1'b1)
			@(posedge clk);
	endtask

	// A matching record gets its last word chosen so that the plaintext sum
	// lands on the low half of the seed.
	task automatic send_record(int length, bit force_match);
		lxc_pkg::in_item_t req;
		logic [31:0]       seed;
		logic [31:0]       key_state;
		logic [15:0]       partial;
		logic [15:0]       key;
		logic [15:0]       plain;
		logic [1:0]        record_func;
		bit                mixed;
		seed = $urandom();
		key_state = seed;
		partial = '0;
		record_func = func_codes[$urandom_range(0, 3)];
		mixed = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < length; i++) begin
			req.func       = mixed ? func_codes[$urandom_range(0, 3)] : record_func;
			req.data_word  = 16'($urandom());
			req.first_word = (i == 0);
			req.seed_value = (i == 0) ? seed : $urandom();
			req.last_word  = (i == length - 1);
			key_state = lcg_advance(key_state);
			key = key_state[31:16];
			if (force_match && req.last_word) begin
				plain = seed[15:0] - partial;
				req.data_word = (req.func == lxc_pkg::FUNC_DECRYPT) ? (plain ^ key) : plain;
			end
			plain = (req.func == lxc_pkg::FUNC_DECRYPT) ? (req.data_word ^ key)
				: req.data_word;
			partial = partial + plain;
			send_word(req);
		end
		record_count++;
	endtask

	task automatic send_noise();
		lxc_pkg::in_item_t req;
		req.func       = func_codes[$urandom_range(0, 3)];
		req.data_word  = 16'($urandom());
		req.first_word = 1'($urandom_range(0, 1));
		req.seed_value = $urandom();
		req.last_word  = 1'($urandom_range(0, 1));
		send_word(req);
	endtask

	always @(posedge clk) begin
		lxc_pkg::out_item_t res;
		pinned_result_t     pin;
		if (arst_n === 1'b1 && din_ch.valid === 1'b1 && din_ch.ready === 1'b1) begin
			res = cipher_predict(din_ch.data);
			pin = pins.pop_front();
			if (pin.pinned)
				res = pin.result;
			expected_words.push_back(res);
		end
	end

	always @(posedge clk) begin
		lxc_pkg::out_item_t want;
		if (dout_ch.valid === 1'b1 && dout_ch.ready === 1'b1) begin
			if (expected_words.size() == 0) begin
				report_mismatch("result with no request pending", dout_ch.data, 0);
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				if (want.sum_matches)
					match_count++;
				if (dout_ch.data.out_word !== want.out_word)
					report_mismatch("out_word", dout_ch.data.out_word, want.out_word);
				if (dout_ch.data.running_sum !== want.running_sum)
					report_mismatch("running_sum", dout_ch.data.running_sum, want.running_sum);
				if (dout_ch.data.last_out !== want.last_out)
					report_mismatch("last_out", dout_ch.data.last_out, want.last_out);
				if (dout_ch.data.sum_matches !== want.sum_matches)
					report_mismatch("sum_matches", dout_ch.data.sum_matches, want.sum_matches);
			end
		end
		if (sink_stall > 0) begin
			dout_ch.ready <= 1'b0;
			sink_stall--;
		end else begin
			dout_ch.ready <= 1'b1;
			sink_stall = pick_gap();
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding.",
			cycle_count, expected_words.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int batch;
		arst_n = 1'b1;
		din_ch.valid = 1'b0;
		din_ch.data = '0;
		dout_ch.ready = 1'b0;
		#1 arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i])
			send_word(stim_table[i].req, stim_table[i].pinned, stim_table[i].result);

		batch = 0;
		while (words_issued < TABLE_ROWS + RANDOM_WORDS) begin
			smooth = (batch % 16) >= 13;
			if (batch == PAUSE_RECORD) begin
				din_ch.valid <= 1'b0;
				@(posedge clk);
				while (expected_words.size() != 0 || pins.size() != 0)
					@(posedge clk);
			end
			if ($urandom_range(0, 99) < 12)
				send_noise();
			else
				send_record(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 8), $urandom_range(0, 99) < 40);
			batch++;
		end
		smooth = 1'b0;

		din_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0 || pins.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_words.size() != 0)
			report_mismatch("results never delivered", expected_words.size(), 0);

		$display("Sent %0d words: %0d directed, the rest in %0d random records and stray words.",
			words_issued, TABLE_ROWS, record_count);
		$display("Checked %0d results, %0d of them closing a record with a matching sum.",
			words_checked, match_count);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/lxc_pkg.sv
rtl/core/lxc_in_if.sv
rtl/core/lxc_out_if.sv
rtl/core/lxc_lcg.sv
rtl/core/lxc_mix.sv
rtl/core/lcg_xor_cipher_with_checksum_core.sv
rtl/core/lxc_checker.sv
verif/lcg_xor_cipher_with_checksum_core_test.sv
